// File: src/vvtcc_pkg.sv
// ----------------------------------------------------------------------------
// vvtcc_pkg
// Shared widths, register codes and payload types of the vertex transform.
// ----------------------------------------------------------------------------
package vvtcc_pkg;

  localparam int CoordW = 21;
  localparam int DiffW  = 22;
  localparam int CoefW  = 20;
  localparam int RotW   = 26;
  localparam int ViewW  = 32;
  localparam int ScrW   = 24;
  localparam int InvW   = 32;
  localparam int CodeW  = 5;
  localparam int QuotW  = 33;

  typedef enum logic [2:0] {
    RegCamera  = 3'd0,
    RegRotX    = 3'd1,
    RegRotY    = 3'd2,
    RegRotZ    = 3'd3,
    RegScales  = 3'd4,
    RegOrigins = 3'd5,
    RegBounds  = 3'd6,
    RegNear    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [62:0] camera;
    logic [59:0] rot_x;
    logic [59:0] rot_y;
    logic [59:0] rot_z;
    logic [63:0] scales;
    logic [63:0] origins;
    logic [63:0] bounds;
    logic [19:0] near;
  } cfg_t;

  typedef struct packed {
    logic [ViewW-1:0] vx;
    logic [ViewW-1:0] vy;
    logic [ViewW-1:0] vz;
    logic             vis;
    logic             eol;
  } view_t;

endpackage

// File: src/vvtcc_ifs.sv
// ----------------------------------------------------------------------------
// vvtcc interfaces
// Vertex, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface vvtcc_vtx_if import vvtcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] vertex_x;
  logic [CoordW-1:0] vertex_y;
  logic [CoordW-1:0] vertex_z;
  logic              last_vertex;
  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface vvtcc_res_if import vvtcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ViewW-1:0] view_x;
  logic [ViewW-1:0] view_y;
  logic [ViewW-1:0] view_z;
  logic [ScrW-1:0]  screen_i;
  logic [ScrW-1:0]  screen_j;
  logic [InvW-1:0]  inv_depth;
  logic [CodeW-1:0] clip_code;
  logic             end_of_line;
  modport source (output valid, view_x, view_y, view_z, screen_i, screen_j, inv_depth,
                  clip_code, end_of_line, input ready);
  modport sink   (input valid, view_x, view_y, view_z, screen_i, screen_j, inv_depth,
                  clip_code, end_of_line, output ready);
endinterface

interface vvtcc_cfg_if import vvtcc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/vvtcc_front.sv
// ----------------------------------------------------------------------------
// vvtcc_front
// Camera subtract, 3x3 rotation, screen scaling and near test; five stages.
// ----------------------------------------------------------------------------
module vvtcc_front import vvtcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cfg_t              cfg_i,
  input  logic              valid_i,
  input  logic [CoordW-1:0] x_i,
  input  logic [CoordW-1:0] y_i,
  input  logic [CoordW-1:0] z_i,
  input  logic              eol_i,
  output logic              valid_o,
  output view_t             view_o
);

  logic [CoordW-1:0]       vin [3];
  logic [59:0]             rot [3];
  logic [4:0]              v_q;
  logic [3:0]              eol_q;
  logic signed [DiffW-1:0] d_q [3];
  logic signed [41:0]      p_q [3][3];
  logic signed [43:0]      acc [3];
  logic signed [43:0]      rnd [3];
  logic signed [RotW-1:0]  r_q [3];
  logic signed [58:0]      sp_q [2];
  logic signed [RotW-1:0]  rz_q;
  logic                    vis_q;
  logic [19:0]             near_eff;
  logic signed [58:0]      ts [2];
  view_t                   view_q;

  function automatic logic [31:0] sat32(input logic signed [58:0] v);
    if (v > 59'sd2147483647) return 32'h7fff_ffff;
    if (v < -59'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  assign vin[0] = x_i;
  assign vin[1] = y_i;
  assign vin[2] = z_i;
  assign rot[0] = cfg_i.rot_x;
  assign rot[1] = cfg_i.rot_y;
  assign rot[2] = cfg_i.rot_z;
  assign near_eff = (cfg_i.near == 20'd0) ? 20'd1 : cfg_i.near;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 44'(p_q[r][0]) + 44'(p_q[r][1]) + 44'(p_q[r][2]);
      rnd[r] = (acc[r] + 44'sd131072) >>> 18;
    end
    for (int k = 0; k < 2; k++) begin
      ts[k] = (sp_q[k] + 59'sd524288) >>> 20;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eol_q <= {eol_q[2:0], eol_i};
      for (int c = 0; c < 3; c++) begin
        d_q[c] <= $signed({vin[c][CoordW-1], vin[c]})
                - $signed({cfg_i.camera[21*c+20], cfg_i.camera[21*c +: 21]});
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_q[r][c] <= d_q[c] * $signed(rot[r][20*c +: 20]);
        end
        r_q[r] <= rnd[r][RotW-1:0];
      end
      sp_q[0] <= r_q[0] * $signed({1'b0, cfg_i.scales[31:0]});
      sp_q[1] <= r_q[1] * $signed({1'b0, cfg_i.scales[63:32]});
      rz_q    <= r_q[2];
      vis_q   <= r_q[2] >= $signed({6'd0, near_eff});
      view_q.vx  <= sat32(ts[0]);
      view_q.vy  <= sat32(ts[1]);
      view_q.vz  <= {{(ViewW-RotW){rz_q[RotW-1]}}, rz_q};
      view_q.vis <= vis_q;
      view_q.eol <= eol_q[3];
    end
  end

  assign valid_o = v_q[4];
  assign view_o  = view_q;

endmodule

// File: src/vvtcc_recip.sv
// ----------------------------------------------------------------------------
// vvtcc_recip
// Rounded reciprocal 2^32/z by restoring division, one quotient bit a stage.
// ----------------------------------------------------------------------------
module vvtcc_recip import vvtcc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  view_t           view_i,
  output logic            valid_o,
  output view_t           view_o,
  output logic [InvW-1:0] inv_o
);

  logic [QuotW:0]      v_q;
  view_t               vw_q  [QuotW+1];
  logic [RotW-1:0]     rem_q [QuotW+1];
  logic [QuotW-1:0]    q_q   [QuotW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QuotW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vw_q[0]  <= view_i;
      rem_q[0] <= '0;
      q_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    localparam int Bit = QuotW - 1 - k;
    logic [RotW-1:0] z;
    logic [QuotW-1:0] num;
    logic [RotW:0]   sh;
    logic            ge;
    logic [RotW:0]   diff;

    assign z    = vw_q[k].vz[RotW-1:0];
    assign num  = {1'b1, 7'd0, z[RotW-1:1]};
    assign sh   = {rem_q[k], num[Bit]};
    assign ge   = sh >= {1'b0, z};
    assign diff = sh - {1'b0, z};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vw_q[k+1]  <= vw_q[k];
        rem_q[k+1] <= ge ? diff[RotW-1:0] : sh[RotW-1:0];
        q_q[k+1]   <= q_q[k] | (QuotW'(ge) << Bit);
      end
    end
  end

  assign valid_o = v_q[QuotW];
  assign view_o  = vw_q[QuotW];
  assign inv_o   = q_q[QuotW][QuotW-1] ? '1 : q_q[QuotW][InvW-1:0];

endmodule

// File: src/vvtcc_screen.sv
// ----------------------------------------------------------------------------
// vvtcc_screen
// Perspective multiply, origin offset, outcode and output register.
// ----------------------------------------------------------------------------
module vvtcc_screen import vvtcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  view_t            view_i,
  input  logic [InvW-1:0]  inv_i,
  output logic             valid_o,
  output view_t            view_o,
  output logic [ScrW-1:0]  si_o,
  output logic [ScrW-1:0]  sj_o,
  output logic [InvW-1:0]  inv_o,
  output logic [CodeW-1:0] code_o
);

  logic [1:0]         v_q;
  view_t              vw_q, vo_q;
  logic [InvW-1:0]    inv_q, invo_q;
  logic signed [64:0] px_q, py_q;
  logic signed [64:0] rx, ry;
  logic signed [49:0] isum, jsum, i8w, j8w;
  logic signed [41:0] i8, j8;
  logic [CodeW-1:0]   code;
  logic [ScrW-1:0]    si_q, sj_q;
  logic [CodeW-1:0]   code_q;

  function automatic logic [23:0] sat24(input logic signed [41:0] v);
    if (v > 42'sd8388607) return 24'h7f_ffff;
    if (v < -42'sd8388608) return 24'h80_0000;
    return v[23:0];
  endfunction

  always_comb begin
    rx   = (px_q + 65'sd32768) >>> 16;
    ry   = (py_q + 65'sd32768) >>> 16;
    isum = $signed({18'd0, cfg_i.origins[31:0]}) + rx[49:0];
    jsum = $signed({18'd0, cfg_i.origins[63:32]}) - ry[49:0];
    i8w  = (isum + 50'sd128) >>> 8;
    j8w  = (jsum + 50'sd128) >>> 8;
    i8   = i8w[41:0];
    j8   = j8w[41:0];
    code = '0;
    code[0] = i8 < $signed({18'd0, cfg_i.bounds[15:0], 8'd0});
    code[1] = i8 > $signed({18'd0, cfg_i.bounds[31:16], 8'd0});
    code[2] = j8 < $signed({18'd0, cfg_i.bounds[47:32], 8'd0});
    code[3] = j8 > $signed({18'd0, cfg_i.bounds[63:48], 8'd0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vw_q  <= view_i;
      inv_q <= inv_i;
      px_q  <= $signed(view_i.vx) * $signed({1'b0, inv_i});
      py_q  <= $signed(view_i.vy) * $signed({1'b0, inv_i});
      vo_q  <= vw_q;
      if (vw_q.vis) begin
        si_q   <= sat24(i8);
        sj_q   <= sat24(j8);
        invo_q <= inv_q;
        code_q <= code;
      end else begin
        si_q   <= '0;
        sj_q   <= '0;
        invo_q <= '0;
        code_q <= CodeW'(16);
      end
    end
  end

  assign valid_o = v_q[1];
  assign view_o  = vo_q;
  assign si_o    = si_q;
  assign sj_o    = sj_q;
  assign inv_o   = invo_q;
  assign code_o  = code_q;

endmodule

// File: src/vertex_view_transform_clip_code.sv
// ----------------------------------------------------------------------------
// vertex_view_transform_clip_code
// World vertex to view space, perspective divide and viewport outcode.
//
// vtx_i takes one world vertex per transfer; res_o gives one result per
// vertex, in order. cfg_i writes the eight setup registers by index; it is
// always ready. The user must write it only while no vertex is in flight;
// the block does not enforce this. The pipeline has five stages of subtract,
// rotate, scale and near test, a 34-stage restoring divider (an input
// stage, then one quotient bit per stage) for the reciprocal depth, a
// perspective multiply stage and the output register.
// Throughput is one vertex per cycle. All stages advance together; when the
// receiver holds off ready with a result waiting, the whole pipeline freezes
// and vtx_i.ready drops in the same cycle, so nothing is lost or repeated.
// Reset empties the pipeline and loads the identity view, unit scales, zero
// origins and bounds, and a near plane of 256.
// ----------------------------------------------------------------------------
module vertex_view_transform_clip_code import vvtcc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  vvtcc_vtx_if.sink   vtx_i,
  vvtcc_res_if.source res_o,
  vvtcc_cfg_if.sink   cfg_i
);

  cfg_t            cfg_q;
  logic            en;
  logic            fv, rv;
  view_t           fview, rview, oview;
  logic [InvW-1:0] rinv;

  assign en          = !res_o.valid || res_o.ready;
  assign vtx_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera  <= '0;
      cfg_q.rot_x   <= 60'd1 << 18;
      cfg_q.rot_y   <= 60'd1 << 38;
      cfg_q.rot_z   <= 60'd1 << 58;
      cfg_q.scales  <= (64'd1 << 52) | (64'd1 << 20);
      cfg_q.origins <= '0;
      cfg_q.bounds  <= '0;
      cfg_q.near    <= 20'd256;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        RegCamera:  cfg_q.camera  <= cfg_i.data[62:0];
        RegRotX:    cfg_q.rot_x   <= cfg_i.data[59:0];
        RegRotY:    cfg_q.rot_y   <= cfg_i.data[59:0];
        RegRotZ:    cfg_q.rot_z   <= cfg_i.data[59:0];
        RegScales:  cfg_q.scales  <= cfg_i.data;
        RegOrigins: cfg_q.origins <= cfg_i.data;
        RegBounds:  cfg_q.bounds  <= cfg_i.data;
        RegNear:    cfg_q.near    <= cfg_i.data[19:0];
        default: ;
      endcase
    end
  end

  vvtcc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg_q),
    .valid_i(vtx_i.valid), .x_i(vtx_i.vertex_x), .y_i(vtx_i.vertex_y),
    .z_i(vtx_i.vertex_z), .eol_i(vtx_i.last_vertex),
    .valid_o(fv), .view_o(fview)
  );

  vvtcc_recip u_recip (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv), .view_i(fview),
    .valid_o(rv), .view_o(rview), .inv_o(rinv)
  );

  vvtcc_screen u_screen (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg_q),
    .valid_i(rv), .view_i(rview), .inv_i(rinv),
    .valid_o(res_o.valid), .view_o(oview), .si_o(res_o.screen_i),
    .sj_o(res_o.screen_j), .inv_o(res_o.inv_depth), .code_o(res_o.clip_code)
  );

  assign res_o.view_x      = oview.vx;
  assign res_o.view_y      = oview.vy;
  assign res_o.view_z      = oview.vz;
  assign res_o.end_of_line = oview.eol;

  a_near_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.clip_code[4] |->
      res_o.clip_code == CodeW'(16) && res_o.inv_depth == '0 &&
      res_o.screen_i == '0 && res_o.screen_j == '0)
    else $error("near-clipped result not cleared");

  a_inv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.clip_code[4] |-> res_o.inv_depth != '0)
    else $error("visible vertex with zero reciprocal");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !vtx_i.ready)
    else $error("input taken while output stalled");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vertex_view_transform_clip_code. Vertices are
// streamed through the block with random idle cycles on both sides. Each
// result is compared field by field with an in-bench fixed-point model of the
// view transform, perspective divide and outcode. The setup registers are
// rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb import vvtcc_pkg::*; ();

  typedef struct packed {
    logic [20:0] x;
    logic [20:0] y;
    logic [20:0] z;
    logic        last;
  } vertex_t;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [23:0] si;
    logic [23:0] sj;
    logic [31:0] inv;
    logic [4:0]  code;
    logic        eol;
  } result_t;

  localparam int Latency = 41;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vvtcc_vtx_if vtx ();
  vvtcc_res_if res ();
  vvtcc_cfg_if cfg ();

  vertex_view_transform_clip_code dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx.sink),
    .res_o  (res.source),
    .cfg_i  (cfg.sink)
  );

  always #5 clk_i = ~clk_i;

  // setup register shadow
  logic [62:0] cam_r;
  logic [59:0] rot_r [3];
  logic [63:0] scales_r, origins_r, bounds_r;
  logic [19:0] near_r;

  vertex_t pending_vertices [$];
  result_t expected_results [$];
  int      errors = 0;
  bit      calm = 1'b0;
  bit      hold_long = 1'b0;
  int      src_gap = 0;
  int      snk_gap = 0;
  longint  cycles = 0;

  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint sat(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint dot_row(logic [59:0] row, longint dx, longint dy, longint dz);
    longint acc;
    acc = dx * longint'($signed(row[19:0])) + dy * longint'($signed(row[39:20]))
        + dz * longint'($signed(row[59:40]));
    return rnd_shift(acc, 18);
  endfunction

  function automatic result_t transform_vertex(vertex_t v);
    result_t r;
    longint dx, dy, dz, rx, ry, rz, vx, vy, vz, nr, i8, j8, ox, oy;
    logic [63:0] z, inv;
    dx = longint'($signed(v.x)) - longint'($signed(cam_r[20:0]));
    dy = longint'($signed(v.y)) - longint'($signed(cam_r[41:21]));
    dz = longint'($signed(v.z)) - longint'($signed(cam_r[62:42]));
    rx = dot_row(rot_r[0], dx, dy, dz);
    ry = dot_row(rot_r[1], dx, dy, dz);
    rz = dot_row(rot_r[2], dx, dy, dz);
    vx = sat(rnd_shift(rx * longint'({32'd0, scales_r[31:0]}), 20), 32);
    vy = sat(rnd_shift(ry * longint'({32'd0, scales_r[63:32]}), 20), 32);
    vz = sat(rz, 32);
    nr = longint'(near_r);
    if (nr < 1) nr = 1;
    r = '0;
    r.vx = vx[31:0];
    r.vy = vy[31:0];
    r.vz = vz[31:0];
    r.eol = v.last;
    if (vz >= nr) begin
      z = vz;
      inv = ((64'd1 << 32) + (z >> 1)) / z;
      if (inv > 64'hFFFF_FFFF) inv = 64'hFFFF_FFFF;
      ox = longint'({32'd0, origins_r[31:0]});
      oy = longint'({32'd0, origins_r[63:32]});
      i8 = rnd_shift(ox + rnd_shift(vx * longint'(inv), 16), 8);
      j8 = rnd_shift(oy - rnd_shift(vy * longint'(inv), 16), 8);
      if (i8 < (longint'(bounds_r[15:0]) << 8)) r.code[0] = 1'b1;
      if (i8 > (longint'(bounds_r[31:16]) << 8)) r.code[1] = 1'b1;
      if (j8 < (longint'(bounds_r[47:32]) << 8)) r.code[2] = 1'b1;
      if (j8 > (longint'(bounds_r[63:48]) << 8)) r.code[3] = 1'b1;
      r.si = 24'(sat(i8, 24));
      r.sj = 24'(sat(j8, 24));
      r.inv = inv[31:0];
    end else begin
      r.code = 5'd16;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx.valid <= 1'b0;
      vtx.vertex_x <= '0;
      vtx.vertex_y <= '0;
      vtx.vertex_z <= '0;
      vtx.last_vertex <= 1'b0;
    end else begin
      if (vtx.valid && vtx.ready) begin
        expected_results.push_back(transform_vertex(pending_vertices.pop_front()));
      end
      if (!vtx.valid || vtx.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          vtx.valid <= 1'b0;
        end else if (pending_vertices.size() > 0 && !(vtx.valid && vtx.ready
                     && pending_vertices.size() == 0)) begin
          vtx.valid <= 1'b1;
          vtx.vertex_x <= pending_vertices[0].x;
          vtx.vertex_y <= pending_vertices[0].y;
          vtx.vertex_z <= pending_vertices[0].z;
          vtx.last_vertex <= pending_vertices[0].last;
          if (!calm && $urandom_range(0, 15) == 0) src_gap <= $urandom_range(1, 11);
        end else begin
          vtx.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (res.valid && res.ready) begin
        got = {res.view_x, res.view_y, res.view_z, res.screen_i, res.screen_j,
               res.inv_depth, res.clip_code, res.end_of_line};
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer");
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.vx !== want.vx) begin
            $error("view_x exp %h got %h", want.vx, got.vx); errors = errors + 1; end
          if (got.vy !== want.vy) begin
            $error("view_y exp %h got %h", want.vy, got.vy); errors = errors + 1; end
          if (got.vz !== want.vz) begin
            $error("view_z exp %h got %h", want.vz, got.vz); errors = errors + 1; end
          if (got.si !== want.si) begin
            $error("screen_i exp %h got %h", want.si, got.si); errors = errors + 1; end
          if (got.sj !== want.sj) begin
            $error("screen_j exp %h got %h", want.sj, got.sj); errors = errors + 1; end
          if (got.inv !== want.inv) begin
            $error("inv_depth exp %h got %h", want.inv, got.inv); errors = errors + 1; end
          if (got.code !== want.code) begin
            $error("clip_code exp %h got %h", want.code, got.code); errors = errors + 1; end
          if (got.eol !== want.eol) begin
            $error("end_of_line exp %h got %h", want.eol, got.eol); errors = errors + 1; end
        end
      end
      if (hold_long) begin
        res.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if (!calm && $urandom_range(0, 15) == 0) snk_gap <= $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("FAIL vertex_view_transform_clip_code");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      RegCamera:  cam_r = val[62:0];
      RegRotX:    rot_r[0] = val[59:0];
      RegRotY:    rot_r[1] = val[59:0];
      RegRotZ:    rot_r[2] = val[59:0];
      RegScales:  scales_r = val;
      RegOrigins: origins_r = val;
      RegBounds:  bounds_r = val;
      default:    near_r = val[19:0];
    endcase
  endtask

  task automatic drain();
    while (pending_vertices.size() > 0 || vtx.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  function automatic logic [20:0] rand_coord(bit wide);
    if (wide) return 21'($urandom);
    return 21'($urandom_range(0, 8191) - 4096);
  endfunction

  function automatic logic [19:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 20'($urandom);
      1: return 20'($urandom_range(0, 524288) - 262144);
      default: return 20'($urandom_range(0, 65536) - 32768);
    endcase
  endfunction

  task automatic push_vertex(logic [20:0] x, logic [20:0] y, logic [20:0] z, logic l);
    vertex_t v;
    v = '{x: x, y: y, z: z, last: l};
    pending_vertices.push_back(v);
  endtask

  task automatic random_setup(int mode);
    logic [63:0] w;
    if (mode == 0) begin
      write_reg(RegCamera, {$urandom_range(0, 1) ? 64'({$urandom, $urandom})
                : 64'({21'($urandom_range(0, 4095) - 2048), 21'($urandom_range(0, 4095)
                - 2048), 21'($urandom_range(0, 4095) - 2048)})});
      write_reg(RegRotX, {4'd0, rand_coef(), rand_coef(), rand_coef()});
      write_reg(RegRotY, {4'd0, rand_coef(), rand_coef(), rand_coef()});
      write_reg(RegRotZ, {4'd0, 20'($urandom_range(131072, 262144)), rand_coef(),
                rand_coef()});
      write_reg(RegScales, {$urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(1 << 18,
                1 << 26)), $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(1 << 18,
                1 << 26))});
      write_reg(RegOrigins, {$urandom, $urandom});
      w = {$urandom, $urandom};
      if ($urandom_range(0, 1)) w = {16'($urandom_range(200, 1000)), 16'($urandom_range(0,
            400)), 16'($urandom_range(300, 2000)), 16'($urandom_range(0, 500))};
      write_reg(RegBounds, w);
      write_reg(RegNear, $urandom_range(0, 3) == 0 ? 64'($urandom) & 64'hFFFFF
                : 64'($urandom_range(0, 2048)));
    end else if (mode == 1) begin
      write_reg(RegCamera, 64'h7FFF_FFFF_FFFF_FFFF);
      write_reg(RegRotX, 64'h0FFF_FFFF_FFFF_FFFF);
      write_reg(RegRotY, 64'h0800_0080_0008_0000);
      write_reg(RegRotZ, 64'h0FFF_FFFF_FFFF_FFFF);
      write_reg(RegScales, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(RegOrigins, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(RegBounds, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(RegNear, 64'hFFFFF);
    end else begin
      write_reg(RegCamera, 64'd0);
      write_reg(RegRotX, 64'd0);
      write_reg(RegRotY, 64'd0);
      write_reg(RegRotZ, 64'h0000_0000_0004_0000);
      write_reg(RegScales, 64'd0);
      write_reg(RegOrigins, 64'd0);
      write_reg(RegBounds, 64'h0000_FFFF_0000_FFFF);
      write_reg(RegNear, 64'd0);
    end
  endtask

  initial begin
    int n;
    cam_r = '0;
    rot_r[0] = 60'd1 << 18;
    rot_r[1] = 60'd1 << 38;
    rot_r[2] = 60'd1 << 58;
    scales_r = (64'd1 << 52) | (64'd1 << 20);
    origins_r = '0;
    bounds_r = '0;
    near_r = 20'd256;
    cfg.valid = 1'b0;
    cfg.index = RegCamera;
    cfg.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset setup, extremes, near plane edges
    push_vertex(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 1'b0);
    push_vertex(21'h100000, 21'h100000, 21'h100000, 1'b1);
    push_vertex(21'd0, 21'd0, 21'd0, 1'b0);
    push_vertex(21'd100, 21'd50, 21'd256, 1'b0);
    push_vertex(21'd100, 21'd50, 21'd255, 1'b1);
    push_vertex(21'd5, 21'd7, 21'd1, 1'b0);
    push_vertex(21'h1FFF00, 21'd256, 21'd512, 1'b1);
    drain();
    write_reg(RegBounds, {16'd600, 16'd0, 16'd800, 16'd0});
    write_reg(RegOrigins, {32'd300 << 16, 32'd400 << 16});
    write_reg(RegNear, 64'd0);
    push_vertex(21'd0, 21'd0, 21'd1, 1'b0);
    push_vertex(21'd0, 21'd0, 21'd0, 1'b0);
    push_vertex(21'h1FFFFF, 21'd0, 21'd1, 1'b1);
    push_vertex(21'd1000, 21'd1000, 21'd256, 1'b0);
    push_vertex(21'h1FFC18, 21'h1FFC18, 21'd256, 1'b1);
    drain();
    write_reg(RegBounds, {16'd0, 16'd600, 16'd0, 16'd800});
    push_vertex(21'd10, 21'd10, 21'd256, 1'b0);
    drain();
    for (int m = 1; m <= 2; m++) begin
      random_setup(m);
      for (int k = 0; k < 6; k++)
        push_vertex(21'($urandom), 21'($urandom), 21'($urandom), 1'($urandom));
      drain();
    end

    // random phases
    for (int p = 0; p < 8; p++) begin
      random_setup(0);
      n = 160;
      if (p == 2) begin
        fork
          begin
            hold_long = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_long = 1'b0;
          end
        join_none
      end
      if (p == 7) calm = 1'b1;
      for (int k = 0; k < n; k++) begin
        bit wide;
        wide = ($urandom_range(0, 4) == 0);
        push_vertex(rand_coord(wide), rand_coord(wide),
                    wide ? rand_coord(1'b1) : 21'($urandom_range(0, 8191) - 1024),
                    1'($urandom));
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS vertex_view_transform_clip_code");
    end else begin
      $display("FAIL vertex_view_transform_clip_code");
    end
    $finish;
  end

endmodule

// File: sim.f
src/vvtcc_pkg.sv
src/vvtcc_ifs.sv
src/vvtcc_front.sv
src/vvtcc_recip.sv
src/vvtcc_screen.sv
src/vertex_view_transform_clip_code.sv
verif/tb.sv
